@@ hw/rtl/rtc_pkg.sv @@
// rtc_pkg: shared types, register indexes and helpers for the closest-hit core.
// No dependencies.
package rtc_pkg;

   typedef enum logic [1:0] {F_IDLE, F_RUN, F_DRAIN, F_PUSH} front_state_type;

   typedef enum logic [2:0] {B_IDLE, B_DIV, B_CHECK, B_POINT, B_EMIT} back_state_type;

   typedef enum logic [3:0] {
      G_H0, G_H1, G_H2, G_Q0, G_Q1, G_Q2, G_DET, G_UN, G_VN, G_TN
   } group_type;

   typedef struct packed {
      logic      valid;
      logic      neg;
      logic      first;
      logic      last;
      group_type grp;
   } acc_ctl_type;

   localparam logic [2:0] REG_ORG_X = 3'd0;
   localparam logic [2:0] REG_ORG_Y = 3'd1;
   localparam logic [2:0] REG_ORG_Z = 3'd2;
   localparam logic [2:0] REG_DIR_X = 3'd3;
   localparam logic [2:0] REG_DIR_Y = 3'd4;
   localparam logic [2:0] REG_DIR_Z = 3'd5;
   localparam logic [2:0] REG_EPS   = 3'd6;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (x < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   function automatic logic [1:0] next3(input logic [1:0] c);
      return (c == 2'd2) ? 2'd0 : c + 2'd1;
   endfunction

endpackage

@@ hw/rtl/rtc_queue.sv @@
// rtc_queue: two-word queue between the geometry front and the distance back.
// Depends on nothing.
module rtc_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wdata,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] rdata,
   output logic         empty
);
   logic [W-1:0] mem_ff [2];
   logic         wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign rdata   = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end
endmodule

@@ hw/rtl/rtc_front.sv @@
// rtc_front: takes a triangle, forms edges, cross and dot products on one shared
// multiplier and classifies it. Depends on rtc_pkg.
module rtc_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [31:0]        v0 [3],
   input  logic signed [31:0]        v1 [3],
   input  logic signed [31:0]        v2 [3],
   input  logic signed [31:0]        org [3],
   input  logic signed [31:0]        dir [3],
   input  logic [15:0]               eps,
   input  logic                      last,
   output logic                      q_push,
   input  logic                      q_full,
   output logic                      q_cand,
   output logic                      q_last,
   output logic signed [66-FRAC_BITS:0] q_tn,
   output logic signed [66-FRAC_BITS:0] q_det
);
   localparam int TW = 64 - FRAC_BITS;
   localparam int SW = TW + 2;
   localparam int PW = SW + 1;

   rtc_pkg::front_state_type state_ff, state_in;
   rtc_pkg::group_type       grp_ff, grp_in;
   logic [1:0]               sub_ff, sub_in;
   rtc_pkg::acc_ctl_type     actl_ff, actl_in;

   logic signed [31:0]    e1_ff [3];
   logic signed [31:0]    e2_ff [3];
   logic signed [31:0]    s_ff [3];
   logic signed [31:0]    h_ff [3];
   logic signed [31:0]    q_ff [3];
   logic signed [SW-1:0]  det_ff, un_ff, vn_ff, tn_ff, acc_ff;
   logic signed [TW-1:0]  term_ff, term_in;
   logic                  last_ff;

   logic                  accept, issue, is_cross, term_last, neg;
   logic signed [31:0]    va [3];
   logic signed [31:0]    vb [3];
   logic signed [31:0]    opa, opb;
   logic signed [63:0]    prod;
   logic [1:0]            c, i1, i2;
   logic signed [SW-1:0]  tx, addend, sum;
   logic signed [PW-1:0]  dp, up, vp, tp;
   logic signed [PW:0]    uv;
   logic                  dneg;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtc_pkg::F_IDLE:  if (push) state_in = rtc_pkg::F_RUN;
         rtc_pkg::F_RUN:   if (term_last && grp_ff == rtc_pkg::G_TN) state_in = rtc_pkg::F_DRAIN;
         rtc_pkg::F_DRAIN: state_in = rtc_pkg::F_PUSH;
         rtc_pkg::F_PUSH:  if (!q_full) state_in = rtc_pkg::F_IDLE;
         default:          state_in = rtc_pkg::F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      full   = (state_ff != rtc_pkg::F_IDLE);
      accept = push && !full;
      issue  = (state_ff == rtc_pkg::F_RUN);
      q_push = (state_ff == rtc_pkg::F_PUSH) && !q_full;
   end

   // operand selection for the shared multiplier
   always_comb begin
      va       = dir;
      vb       = dir;
      c        = 2'd0;
      is_cross = 1'b1;
      case (grp_ff)
         rtc_pkg::G_H0:  begin va = dir;   vb = e2_ff; c = 2'd0; end
         rtc_pkg::G_H1:  begin va = dir;   vb = e2_ff; c = 2'd1; end
         rtc_pkg::G_H2:  begin va = dir;   vb = e2_ff; c = 2'd2; end
         rtc_pkg::G_Q0:  begin va = s_ff;  vb = e1_ff; c = 2'd0; end
         rtc_pkg::G_Q1:  begin va = s_ff;  vb = e1_ff; c = 2'd1; end
         rtc_pkg::G_Q2:  begin va = s_ff;  vb = e1_ff; c = 2'd2; end
         rtc_pkg::G_DET: begin va = e1_ff; vb = h_ff;  is_cross = 1'b0; end
         rtc_pkg::G_UN:  begin va = s_ff;  vb = h_ff;  is_cross = 1'b0; end
         rtc_pkg::G_VN:  begin va = dir;   vb = q_ff;  is_cross = 1'b0; end
         rtc_pkg::G_TN:  begin va = e2_ff; vb = q_ff;  is_cross = 1'b0; end
         default:        begin va = dir;   vb = dir;   is_cross = 1'b0; end
      endcase
      i1 = rtc_pkg::next3(c);
      i2 = rtc_pkg::next3(i1);
      if (is_cross) begin
         term_last = (sub_ff == 2'd1);
         neg       = (sub_ff != 2'd0);
         opa       = (sub_ff == 2'd0) ? va[i1] : va[i2];
         opb       = (sub_ff == 2'd0) ? vb[i2] : vb[i1];
      end else begin
         term_last = (sub_ff == 2'd2);
         neg       = 1'b0;
         opa       = va[sub_ff];
         opb       = vb[sub_ff];
      end
      prod    = opa * opb;
      term_in = TW'(prod >>> FRAC_BITS);
      grp_in  = grp_ff;
      sub_in  = sub_ff;
      if (accept) begin
         grp_in = rtc_pkg::G_H0;
         sub_in = 2'd0;
      end else if (issue) begin
         if (term_last) begin
            grp_in = (grp_ff == rtc_pkg::G_TN) ? rtc_pkg::G_H0
                                               : rtc_pkg::group_type'(grp_ff + 4'd1);
            sub_in = 2'd0;
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end
      actl_in = '{valid: issue, neg: neg, first: (sub_ff == 2'd0), last: term_last,
                  grp: grp_ff};
   end

   // accumulate
   always_comb begin
      tx     = SW'(term_ff);
      addend = actl_ff.neg ? -tx : tx;
      sum    = actl_ff.first ? addend : acc_ff + addend;
   end

   // classify: fold the sign of det, then the bounds
   always_comb begin
      dneg   = det_ff[SW-1];
      dp     = dneg ? -PW'(det_ff) : PW'(det_ff);
      up     = dneg ? -PW'(un_ff) : PW'(un_ff);
      vp     = dneg ? -PW'(vn_ff) : PW'(vn_ff);
      tp     = dneg ? -PW'(tn_ff) : PW'(tn_ff);
      uv     = (PW+1)'(up) + (PW+1)'(vp);
      q_cand = (dp > PW'($signed({1'b0, eps}))) && !up[PW-1] && !(up > dp)
               && !vp[PW-1] && !(uv > (PW+1)'(dp)) && (tp > PW'(0));
      q_tn   = tp;
      q_det  = dp;
      q_last = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rtc_pkg::F_IDLE;
         grp_ff        <= rtc_pkg::G_H0;
         sub_ff        <= 2'd0;
         actl_ff.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         sub_ff   <= sub_in;
         actl_ff  <= actl_in;
      end
      term_ff <= term_in;
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= rtc_pkg::sat32(64'(v1[i]) - 64'(v0[i]));
            e2_ff[i] <= rtc_pkg::sat32(64'(v2[i]) - 64'(v0[i]));
            s_ff[i]  <= rtc_pkg::sat32(64'(org[i]) - 64'(v0[i]));
         end
         last_ff <= last;
      end
      if (actl_ff.valid) begin
         acc_ff <= sum;
         if (actl_ff.last) begin
            case (actl_ff.grp)
               rtc_pkg::G_H0:  h_ff[0] <= rtc_pkg::sat32(64'(sum));
               rtc_pkg::G_H1:  h_ff[1] <= rtc_pkg::sat32(64'(sum));
               rtc_pkg::G_H2:  h_ff[2] <= rtc_pkg::sat32(64'(sum));
               rtc_pkg::G_Q0:  q_ff[0] <= rtc_pkg::sat32(64'(sum));
               rtc_pkg::G_Q1:  q_ff[1] <= rtc_pkg::sat32(64'(sum));
               rtc_pkg::G_Q2:  q_ff[2] <= rtc_pkg::sat32(64'(sum));
               rtc_pkg::G_DET: det_ff  <= sum;
               rtc_pkg::G_UN:  un_ff   <= sum;
               rtc_pkg::G_VN:  vn_ff   <= sum;
               rtc_pkg::G_TN:  tn_ff   <= sum;
               default:        ;
            endcase
         end
      end
   end
endmodule

@@ hw/rtl/rtc_back.sv @@
// rtc_back: divides for the distance, keeps the closest hit, forms the point and
// holds the result word. Depends on rtc_pkg.
module rtc_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  logic                    q_cand,
   input  logic                    q_last,
   input  logic [66-FRAC_BITS:0]   q_tn,
   input  logic [66-FRAC_BITS:0]   q_det,
   input  logic signed [31:0]      org [3],
   input  logic signed [31:0]      dir [3],
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic                    hit_found,
   output logic [30:0]             hit_distance,
   output logic signed [31:0]      hit_x,
   output logic signed [31:0]      hit_y,
   output logic signed [31:0]      hit_z
);
   localparam int PW = 67 - FRAC_BITS;
   localparam int SH = 31 - FRAC_BITS;
   localparam int CW = PW + SH;

   rtc_pkg::back_state_type state_ff, state_in;
   logic [4:0]          cnt_ff;
   logic [30:0]         t_ff, closest_ff, nlo_ff;
   logic [PW-1:0]       rem_ff, det_ff, rem_in;
   logic                last_ff, any_ff, out_valid_ff;
   logic signed [31:0]  best_ff [3];
   logic signed [63:0]  prod_ff;
   logic signed [31:0]  dir_sel, org_sel, point;
   logic [PW:0]         trial;
   logic                ge, sat_q, keep, emit, take;
   logic [1:0]          pidx, widx;

   assign rsp_empty = !out_valid_ff;

   // datapath helpers
   always_comb begin
      sat_q  = CW'(q_tn) >= (CW'(q_det) << SH);
      trial  = {rem_ff, nlo_ff[30]};
      ge     = trial >= {1'b0, det_ff};
      rem_in = ge ? PW'(trial - {1'b0, det_ff}) : PW'(trial);
      keep   = (t_ff != '0) && (!any_ff || t_ff < closest_ff);
      pidx   = cnt_ff[1:0];
      widx   = pidx - 2'd1;
      case (pidx)
         2'd0:    dir_sel = dir[0];
         2'd1:    dir_sel = dir[1];
         default: dir_sel = dir[2];
      endcase
      case (widx)
         2'd0:    org_sel = org[0];
         2'd1:    org_sel = org[1];
         default: org_sel = org[2];
      endcase
      point = rtc_pkg::sat32((prod_ff >>> FRAC_BITS) + 64'(org_sel));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtc_pkg::B_IDLE: begin
            if (!q_empty) begin
               state_in = (q_cand && !sat_q) ? rtc_pkg::B_DIV : rtc_pkg::B_CHECK;
            end
         end
         rtc_pkg::B_DIV:   if (cnt_ff == 5'd30) state_in = rtc_pkg::B_CHECK;
         rtc_pkg::B_CHECK: begin
            if (keep) begin
               state_in = rtc_pkg::B_POINT;
            end else begin
               state_in = last_ff ? rtc_pkg::B_EMIT : rtc_pkg::B_IDLE;
            end
         end
         rtc_pkg::B_POINT: begin
            if (pidx == 2'd3) state_in = last_ff ? rtc_pkg::B_EMIT : rtc_pkg::B_IDLE;
         end
         rtc_pkg::B_EMIT:  if (!out_valid_ff || rsp_pop) state_in = rtc_pkg::B_IDLE;
         default:          state_in = rtc_pkg::B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop = (state_ff == rtc_pkg::B_IDLE) && !q_empty;
      take  = (state_ff == rtc_pkg::B_CHECK) && keep;
      emit  = (state_ff == rtc_pkg::B_EMIT) && (!out_valid_ff || rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtc_pkg::B_IDLE;
         any_ff       <= 1'b0;
         closest_ff   <= '1;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) best_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (take) begin
            any_ff     <= 1'b1;
            closest_ff <= t_ff;
         end
         if (state_ff == rtc_pkg::B_POINT && pidx != 2'd0) begin
            best_ff[widx] <= point;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
            any_ff       <= 1'b0;
            closest_ff   <= '1;
            for (int i = 0; i < 3; i++) best_ff[i] <= '0;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      case (state_ff)
         rtc_pkg::B_IDLE: begin
            last_ff <= q_last;
            det_ff  <= q_det;
            rem_ff  <= q_tn >> SH;
            nlo_ff  <= 31'(q_tn[SH-1:0]) << FRAC_BITS;
            cnt_ff  <= '0;
            t_ff    <= (q_cand && sat_q) ? '1 : '0;
         end
         rtc_pkg::B_DIV: begin
            rem_ff <= rem_in;
            nlo_ff <= nlo_ff << 1;
            t_ff   <= {t_ff[29:0], ge};
            cnt_ff <= cnt_ff + 5'd1;
         end
         rtc_pkg::B_CHECK: cnt_ff <= '0;
         rtc_pkg::B_POINT: begin
            prod_ff <= $signed({1'b0, t_ff}) * dir_sel;
            cnt_ff  <= cnt_ff + 5'd1;
         end
         default: cnt_ff <= cnt_ff;
      endcase
      if (emit) begin
         hit_found    <= any_ff;
         hit_distance <= any_ff ? closest_ff : '0;
         hit_x        <= any_ff ? best_ff[0] : '0;
         hit_y        <= any_ff ? best_ff[1] : '0;
         hit_z        <= any_ff ? best_ff[2] : '0;
      end
   end

   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      any_ff |-> (closest_ff != '0))
      else $error("held hit has zero distance");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> (!any_ff && out_valid_ff))
      else $error("state not cleared after result word");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rtc_pkg::B_DIV) |-> (cnt_ff <= 5'd30))
      else $error("divide step count overrun");

   a_keep_closer: assert property (@(posedge clock) disable iff (reset)
      (take && any_ff) |=> (closest_ff < $past(closest_ff)))
      else $error("kept hit is not closer");
endmodule

@@ hw/rtl/ray_triangle_closest_hit_core.sv @@
// Closest-hit ray/triangle core: register file, front, queue and back.
// Depends on rtc_pkg, rtc_front, rtc_queue and rtc_back.
// Load the ray through the csr_ port (origin, direction, parallel epsilon), then push
// triangles; the word marked last_triangle yields one result word holding the closest
// positive hit of the query, then the hit state clears. The front takes one triangle at a
// time and issues its 24 products on its one multiplier; the back skips the divide for a
// triangle that is no candidate or whose distance saturates, runs the 31-step restoring
// divide for the others and the three hit-point products for a kept hit, and loads the
// result word on a last triangle. A two-word queue lets the front run ahead of the back,
// and the result word waits in its own register until popped.
module ray_triangle_closest_hit_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_v0_x,
   input  logic signed [31:0] req_v0_y,
   input  logic signed [31:0] req_v0_z,
   input  logic signed [31:0] req_v1_x,
   input  logic signed [31:0] req_v1_y,
   input  logic signed [31:0] req_v1_z,
   input  logic signed [31:0] req_v2_x,
   input  logic signed [31:0] req_v2_y,
   input  logic signed [31:0] req_v2_z,
   input  logic               req_last_triangle,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic               rsp_hit_found,
   output logic [30:0]        rsp_hit_distance,
   output logic signed [31:0] rsp_hit_x,
   output logic signed [31:0] rsp_hit_y,
   output logic signed [31:0] rsp_hit_z
);
   localparam int PW = 67 - FRAC_BITS;
   localparam int QW = 2 + 2 * PW;

   logic signed [31:0] org_ff [3];
   logic signed [31:0] dir_ff [3];
   logic [15:0]        eps_ff;
   logic signed [31:0] v0 [3];
   logic signed [31:0] v1 [3];
   logic signed [31:0] v2 [3];
   logic               f_push, f_full, f_cand, f_last, b_pop, b_empty, b_cand, b_last;
   logic signed [PW-1:0] f_tn, f_det;
   logic [PW-1:0]      b_tn, b_det;
   logic [QW-1:0]      q_wdata, q_rdata;
   logic               csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign v0 = '{req_v0_x, req_v0_y, req_v0_z};
   assign v1 = '{req_v1_x, req_v1_y, req_v1_z};
   assign v2 = '{req_v2_x, req_v2_y, req_v2_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= 32'sd1 <<< FRAC_BITS;
         eps_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rtc_pkg::REG_ORG_X: org_ff[0] <= csr_data;
            rtc_pkg::REG_ORG_Y: org_ff[1] <= csr_data;
            rtc_pkg::REG_ORG_Z: org_ff[2] <= csr_data;
            rtc_pkg::REG_DIR_X: dir_ff[0] <= csr_data;
            rtc_pkg::REG_DIR_Y: dir_ff[1] <= csr_data;
            rtc_pkg::REG_DIR_Z: dir_ff[2] <= csr_data;
            rtc_pkg::REG_EPS:   eps_ff    <= csr_data[15:0];
            default:            eps_ff    <= eps_ff;
         endcase
      end
   end

   rtc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .full   (req_full),
      .v0     (v0),
      .v1     (v1),
      .v2     (v2),
      .org    (org_ff),
      .dir    (dir_ff),
      .eps    (eps_ff),
      .last   (req_last_triangle),
      .q_push (f_push),
      .q_full (f_full),
      .q_cand (f_cand),
      .q_last (f_last),
      .q_tn   (f_tn),
      .q_det  (f_det)
   );

   assign q_wdata = {f_cand, f_last, f_tn, f_det};
   assign {b_cand, b_last, b_tn, b_det} = q_rdata;

   rtc_queue #(.W(QW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (q_wdata),
      .full  (f_full),
      .pop   (b_pop),
      .rdata (q_rdata),
      .empty (b_empty)
   );

   rtc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (b_empty),
      .q_pop        (b_pop),
      .q_cand       (b_cand),
      .q_last       (b_last),
      .q_tn         (b_tn),
      .q_det        (b_det),
      .org          (org_ff),
      .dir          (dir_ff),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .hit_found    (rsp_hit_found),
      .hit_distance (rsp_hit_distance),
      .hit_x        (rsp_hit_x),
      .hit_y        (rsp_hit_y),
      .hit_z        (rsp_hit_z)
   );
endmodule
